[design/gfau_pkg.sv]
// gfau_pkg: shared types, constants and the GF(2^m) multiply function
// for the GF(2^m) arithmetic unit. No dependencies.

package gfau_pkg;

  // Widest field supported; element registers are this wide
  localparam int unsigned MAX_WIDTH = 8;
  // Port field widths
  localparam int unsigned ModeW     = 2;
  localparam int unsigned OperandW  = 8;
  localparam int unsigned ResultW   = 8;
  localparam int unsigned FwidthW   = 4;
  localparam int unsigned PolyW     = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;
  // Exponent bits walked by the square-and-multiply chain
  localparam int unsigned ExpW      = OperandW;
  // Decode stage + one stage per exponent bit + final multiply stage
  localparam int unsigned PipeDepth = ExpW + 2;

  typedef logic [MAX_WIDTH-1:0] elem_t;
  typedef logic [MAX_WIDTH:0]   red_t;
  typedef logic [ExpW-1:0]      exp_t;

  typedef enum logic [ModeW-1:0] {
    MODE_MUL = 2'd0,
    MODE_DIV = 2'd1,
    MODE_POW = 2'd2,
    MODE_INV = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIELD_WIDTH   = 1'b0,
    CFG_POLY_LOW_BITS = 1'b1
  } cfg_idx_e;

  // Derived field description
  typedef struct packed {
    elem_t mask;     // 2^m - 1
    red_t  red;      // x^m + low polynomial bits
    exp_t  inv_exp;  // 2^m - 2
  } cfg_t;

  // Item state carried down the pipeline
  typedef struct packed {
    elem_t base;     // running square of the base
    elem_t acc;      // running product
    exp_t  expn;     // exponent bits not yet consumed, LSB next
    elem_t coef;     // factor applied in the last stage
    logic  zero;     // force a zero result
    logic  fault;    // division by zero or inverse of zero
  } pipe_t;

  // Shift-and-add product modulo the field polynomial
  function automatic elem_t gf_mul(elem_t a, elem_t b, elem_t mask, red_t red);
    red_t  sh;
    red_t  top;
    elem_t r;
    begin
      top = red & ~{1'b0, mask};
      sh  = {1'b0, a & mask};
      r   = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        if (b[i] & mask[i]) r = r ^ sh[MAX_WIDTH-1:0];
        sh = sh << 1;
        if ((sh & top) != '0) sh = sh ^ red;
      end
      return r & mask;
    end
  endfunction

endpackage

[design/gfau_if.sv]
// gfau_if: valid/ready channel interfaces for the GF(2^m) arithmetic unit:
// input items, result items and configuration writes. Depends on gfau_pkg.

interface gfau_in_if;
  logic                         valid;
  logic                         ready;
  logic [gfau_pkg::ModeW-1:0]    mode;
  logic [gfau_pkg::OperandW-1:0] operand_a;
  logic [gfau_pkg::OperandW-1:0] operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

interface gfau_out_if;
  logic                        valid;
  logic                        ready;
  logic [gfau_pkg::ResultW-1:0] result;
  logic                        zero_fault;

  modport source (output valid, output result, output zero_fault, input ready);
  modport sink   (input valid, input result, input zero_fault, output ready);
endinterface

interface gfau_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gfau_pkg::CfgIdxW-1:0]  index;
  logic [gfau_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/gfau_cfg.sv]
// gfau_cfg: field width and polynomial registers, plus the derived mask,
// reduction word and inverse exponent. Depends on gfau_pkg.

module gfau_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [gfau_pkg::CfgIdxW-1:0]  index_i,
  input  logic [gfau_pkg::CfgDataW-1:0] data_i,
  output logic                          ready_o,
  output gfau_pkg::cfg_t                cfg_o
);

  logic [gfau_pkg::FwidthW-1:0] fwidth_q, fwidth_d;
  logic [gfau_pkg::PolyW-1:0]   poly_q, poly_d;
  logic [gfau_pkg::FwidthW-1:0] m_eff;
  gfau_pkg::red_t               top;
  gfau_pkg::elem_t              mask;

  assign ready_o = 1'b1;

  // Register writes
  always_comb begin
    fwidth_d = fwidth_q;
    poly_d   = poly_q;
    if (valid_i) begin
      case (gfau_pkg::cfg_idx_e'(index_i))
        gfau_pkg::CFG_FIELD_WIDTH:   fwidth_d = data_i[gfau_pkg::FwidthW-1:0];
        gfau_pkg::CFG_POLY_LOW_BITS: poly_d   = data_i[gfau_pkg::PolyW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwidth_q <= gfau_pkg::FwidthW'(8);
      poly_q   <= gfau_pkg::PolyW'(29);
    end else begin
      fwidth_q <= fwidth_d;
      poly_q   <= poly_d;
    end
  end

  // Clamp m into the supported range and derive the field words
  always_comb begin
    if (fwidth_q < gfau_pkg::FwidthW'(2)) begin
      m_eff = gfau_pkg::FwidthW'(2);
    end else if (fwidth_q > gfau_pkg::FwidthW'(gfau_pkg::MAX_WIDTH)) begin
      m_eff = gfau_pkg::FwidthW'(gfau_pkg::MAX_WIDTH);
    end else begin
      m_eff = fwidth_q;
    end
    top           = gfau_pkg::red_t'(1) << m_eff;
    mask          = gfau_pkg::elem_t'(top - gfau_pkg::red_t'(1));
    cfg_o.mask    = mask;
    cfg_o.red     = top | {1'b0, gfau_pkg::elem_t'(poly_q) & mask};
    cfg_o.inv_exp = gfau_pkg::exp_t'(mask) - gfau_pkg::exp_t'(1);
  end

endmodule

[design/gfau_decode.sv]
// gfau_decode: entry stage; maps each mode onto base^exponent * coefficient
// and flags the zero cases. Depends on gfau_pkg.

module gfau_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gfau_pkg::cfg_t                cfg_i,
  input  logic                          valid_i,
  input  logic [gfau_pkg::ModeW-1:0]    mode_i,
  input  logic [gfau_pkg::OperandW-1:0] operand_a_i,
  input  logic [gfau_pkg::OperandW-1:0] operand_b_i,
  output logic                          ready_o,
  output logic                          valid_o,
  output gfau_pkg::pipe_t               data_o,
  input  logic                          ready_i
);

  logic            valid_q;
  gfau_pkg::pipe_t data_q, data_d;
  gfau_pkg::elem_t a, b;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Operand masking and mode mapping
  always_comb begin
    a           = gfau_pkg::elem_t'(operand_a_i) & cfg_i.mask;
    b           = gfau_pkg::elem_t'(operand_b_i) & cfg_i.mask;
    data_d.acc  = gfau_pkg::elem_t'(1);
    data_d.base = a;
    data_d.expn = cfg_i.inv_exp;
    data_d.coef = gfau_pkg::elem_t'(1);
    data_d.zero  = 1'b0;
    data_d.fault = 1'b0;
    case (gfau_pkg::mode_e'(mode_i))
      gfau_pkg::MODE_MUL: begin
        data_d.expn = gfau_pkg::exp_t'(1);
        data_d.coef = b;
      end
      gfau_pkg::MODE_DIV: begin
        data_d.base  = b;
        data_d.coef  = a;
        data_d.fault = (b == '0);
      end
      gfau_pkg::MODE_POW: begin
        data_d.expn = gfau_pkg::exp_t'(operand_b_i);
        data_d.zero = (a == '0);
      end
      gfau_pkg::MODE_INV: begin
        data_d.fault = (a == '0);
      end
      default: ;
    endcase
    data_d.zero = data_d.zero | data_d.fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

[design/gfau_pow_stage.sv]
// gfau_pow_stage: one square-and-multiply step on the low exponent bit.
// Depends on gfau_pkg (gf_mul, pipe_t).

module gfau_pow_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gfau_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  gfau_pkg::pipe_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output gfau_pkg::pipe_t data_o,
  input  logic            ready_i
);

  logic            valid_q;
  gfau_pkg::pipe_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Multiply in the base when the bit is set, square the base
  always_comb begin
    data_d      = data_i;
    data_d.acc  = data_i.expn[0]
                ? gfau_pkg::gf_mul(data_i.acc, data_i.base, cfg_i.mask, cfg_i.red)
                : data_i.acc;
    data_d.base = gfau_pkg::gf_mul(data_i.base, data_i.base, cfg_i.mask, cfg_i.red);
    data_d.expn = data_i.expn >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

[design/gfau_final.sv]
// gfau_final: last multiply by the coefficient, zero override and the
// output register. Depends on gfau_pkg.

module gfau_final (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gfau_pkg::cfg_t               cfg_i,
  input  logic                         valid_i,
  input  gfau_pkg::pipe_t              data_i,
  output logic                         ready_o,
  output logic                         valid_o,
  output logic [gfau_pkg::ResultW-1:0] result_o,
  output logic                         zero_fault_o,
  input  logic                         ready_i
);

  logic                         valid_q;
  logic [gfau_pkg::ResultW-1:0] result_q, result_d;
  logic                         fault_q;
  gfau_pkg::elem_t              prod;

  assign ready_o      = !valid_q || ready_i;
  assign valid_o      = valid_q;
  assign result_o     = result_q;
  assign zero_fault_o = fault_q;

  always_comb begin
    prod     = gfau_pkg::gf_mul(data_i.acc, data_i.coef, cfg_i.mask, cfg_i.red);
    result_d = data_i.zero ? '0 : gfau_pkg::ResultW'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_d;
      fault_q  <= data_i.fault;
    end
  end

endmodule

[design/gf2m_arithmetic_unit.sv]
// GF(2^m) arithmetic unit: multiply, divide, power and inverse over a
// configurable field. Pipeline: entry stage, eight square-and-multiply
// stages, one for each exponent bit, then the final multiply and output
// register. Throughput one beat per cycle; each stage stalls only
// when full and blocked. Async active-low reset empties the pipe and sets
// m = 8 with polynomial x^8+x^4+x^3+x^2+1.

module gf2m_arithmetic_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  gfau_cfg_if.sink  cfg_i,
  gfau_in_if.sink   in_i,
  gfau_out_if.source out_o
);

  gfau_pkg::cfg_t  cfg;
  gfau_pkg::pipe_t stg_data  [0:gfau_pkg::ExpW];
  logic            stg_valid [0:gfau_pkg::ExpW];
  logic            stg_ready [0:gfau_pkg::ExpW];

  // Configuration registers
  gfau_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cfg_i.valid),
    .index_i (cfg_i.index),
    .data_i  (cfg_i.data),
    .ready_o (cfg_i.ready),
    .cfg_o   (cfg)
  );

  // Entry stage
  gfau_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (in_i.valid),
    .mode_i      (in_i.mode),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .ready_o     (in_i.ready),
    .valid_o     (stg_valid[0]),
    .data_o      (stg_data[0]),
    .ready_i     (stg_ready[0])
  );

  // Square-and-multiply chain, one stage per exponent bit
  for (genvar k = 0; k < gfau_pkg::ExpW; k++) begin : g_pow
    gfau_pow_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg),
      .valid_i (stg_valid[k]),
      .data_i  (stg_data[k]),
      .ready_o (stg_ready[k]),
      .valid_o (stg_valid[k+1]),
      .data_o  (stg_data[k+1]),
      .ready_i (stg_ready[k+1])
    );
  end

  // Final multiply and output register
  gfau_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .valid_i      (stg_valid[gfau_pkg::ExpW]),
    .data_i       (stg_data[gfau_pkg::ExpW]),
    .ready_o      (stg_ready[gfau_pkg::ExpW]),
    .valid_o      (out_o.valid),
    .result_o     (out_o.result),
    .zero_fault_o (out_o.zero_fault),
    .ready_i      (out_o.ready)
  );

endmodule

[design/gfau_checker.sv]
// gfau_checker: port-level assertions for the GF(2^m) arithmetic unit and
// the bind that attaches them. Depends on gfau_pkg and gf2m_arithmetic_unit.

module gfau_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [gfau_pkg::ResultW-1:0] result_i,
  input logic                         zero_fault_i
);

  localparam int unsigned CntW = $clog2(gfau_pkg::PipeDepth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Beats in flight
  always_comb begin
    cnt_d = cnt_q;
    if (in_beat && !out_beat) cnt_d = cnt_q + CntW'(1);
    if (!in_beat && out_beat) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(result_i) && $stable(zero_fault_i))
    else $error("result beat changed while stalled");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_fault_i |-> result_i == '0)
    else $error("faulted beat carries a nonzero result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result beat without a pending input beat");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(gfau_pkg::PipeDepth))
    else $error("more beats in flight than pipeline stages");

endmodule

bind gf2m_arithmetic_unit gfau_checker u_gfau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .result_i     (out_o.result),
  .zero_fault_i (out_o.zero_fault)
);
